@@ rtl/core/text_console_writer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property forms used by the console assertions, clocked on the
// block clock and switched off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, codes, controller/datapath interface types and the
// tab-stop helper used to build the tab table.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Default geometry
   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 8;

   // Port field widths
   localparam int KIND_W   = 3;
   localparam int COORD_W  = 7;
   localparam int BYTE_W   = 8;
   localparam int OCOL_W   = 7;
   localparam int OROW_W   = 5;
   localparam int COLOR_W  = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CELL_W   = 16;

   // Internal cursor widths: hold any coordinate plus one
   localparam int POS_W     = 8;
   localparam int ROW_POS_W = 7;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_STREAM = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SCROLL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

   // Character codes
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_FG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_BG = 1'b1;

   // Fill colors after reset
   localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
   localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;
   localparam logic [CELL_W-1:0]  RESET_BLANK = {RESET_BG, RESET_FG, CHAR_SPACE};

   // Datapath operations
   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_INIT_FILL = 3'd1,
      OP_SETUP     = 3'd2,
      OP_READ      = 3'd3,
      OP_CAPTURE   = 3'd4,
      OP_COPY      = 3'd5,
      OP_FILL      = 3'd6,
      OP_STREAM    = 3'd7
   } op_type;

   typedef struct packed {
      op_type op;
      logic   latch;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              nul;
      logic              need_scroll;
      logic              in_range;
      logic              lines_zero;
      logic              lines_full;
      logic              cnt_at_end;
      logic              cnt_at_copy_end;
   } sts_type;

   // Next tab stop after column cur, capped at limit (elaboration only)
   function automatic int tab_next(input int cur, input int step, input int limit);
      int stop;
      stop = step;
      for (int k = 0; k < 256; k++) begin
         if (stop <= cur) begin
            stop = stop + step;
         end
      end
      if (stop > limit) begin
         stop = limit;
      end
      return stop;
   endfunction

endpackage

@@ rtl/core/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// Text console controller
// Sequences the cell store sweeps, cell accesses and the result word
// handshake for one item at a time.
// ----------------------------------------------------------------------------
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_INIT     = 10'b0000000001,
      ST_IDLE     = 10'b0000000010,
      ST_DISPATCH = 10'b0000000100,
      ST_READ     = 10'b0000001000,
      ST_CAPTURE  = 10'b0000010000,
      ST_COPY     = 10'b0000100000,
      ST_DRAIN    = 10'b0001000000,
      ST_FILL     = 10'b0010000000,
      ST_STREAM   = 10'b0100000000,
      ST_DONE     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.latch    = 1'b0;
      cmd.load_rsp = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.op = OP_INIT_FILL;
            if (sts.cnt_at_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.op = OP_SETUP;
            unique case (sts.kind)
               KIND_STREAM: begin
                  if (sts.nul) begin
                     state_in = ST_DONE;
                  end else if (sts.need_scroll) begin
                     state_in = ST_COPY;
                  end else begin
                     state_in = ST_STREAM;
                  end
               end
               KIND_PUT, KIND_READ: begin
                  state_in = sts.in_range ? ST_READ : ST_DONE;
               end
               KIND_SCROLL: begin
                  if (sts.lines_zero) begin
                     state_in = ST_DONE;
                  end else if (sts.lines_full) begin
                     state_in = ST_FILL;
                  end else begin
                     state_in = ST_COPY;
                  end
               end
               KIND_CLEAR: begin
                  state_in = ST_FILL;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_READ: begin
            cmd.op   = OP_READ;
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            cmd.op   = OP_CAPTURE;
            state_in = ST_DONE;
         end
         ST_COPY: begin
            cmd.op = OP_COPY;
            if (sts.cnt_at_copy_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // let the last moved cell retire on the write port
            state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.op = OP_FILL;
            if (sts.cnt_at_end) begin
               state_in = (sts.kind == KIND_STREAM) ? ST_STREAM : ST_DONE;
            end
         end
         ST_STREAM: begin
            cmd.op   = OP_STREAM;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // Hold the result word until taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// Text console datapath
// Cell store, cursor, fill colors, item and result registers, sweep counter
// and the stream position logic.
// ----------------------------------------------------------------------------
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF,
   parameter int TAB_STOP = TAB_STOP_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic                 req_starts_string,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [BYTE_W-1:0]    req_char_code,
   input  logic [BYTE_W-1:0]    req_attr,
   input  logic [BYTE_W-1:0]    req_scroll_lines,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata,
   output logic [BYTE_W-1:0]    rsp_old_char,
   output logic [OCOL_W-1:0]    rsp_cursor_col,
   output logic [OROW_W-1:0]    rsp_cursor_row
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int COL_IDX_W = $clog2(COLUMNS);

   // Item registers
   logic [KIND_W-1:0]  item_kind_ff;
   logic               item_start_ff;
   logic [COORD_W-1:0] item_col_ff;
   logic [COORD_W-1:0] item_row_ff;
   logic [BYTE_W-1:0]  item_char_ff;
   logic [BYTE_W-1:0]  item_attr_ff;
   logic [BYTE_W-1:0]  item_lines_ff;

   // Control and working registers
   logic [COLOR_W-1:0]   fill_fg_ff, fill_bg_ff;
   logic [POS_W-1:0]     cur_col_ff, cur_col_in;
   logic [ROW_POS_W-1:0] cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0]    cnt_ff, cnt_in;
   logic                 copy_wr_vld_ff;
   logic [ADDR_W-1:0]    copy_wr_addr_ff;
   logic [POS_W-1:0]     pos_col_ff;
   logic [ROW_POS_W-1:0] pos_row_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    shift_ff;
   logic [ADDR_W-1:0]    copy_last_ff;
   logic [BYTE_W-1:0]    old_ff;
   logic [CELL_W-1:0]    rd_data_ff;
   logic [BYTE_W-1:0]    rsp_old_char_ff;
   logic [OCOL_W-1:0]    rsp_cursor_col_ff;
   logic [OROW_W-1:0]    rsp_cursor_row_ff;

   // Cell store
   logic [CELL_W-1:0] cell_mem [CELLS];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   // Position logic
   logic [POS_W-1:0]  cx0, cx1, cy0, cy1, cy2, row_sel, col_sel, lines_sel;
   logic              wrap, need_scroll, is_stream, printable;
   logic [15:0]       addr_full, shift_full;
   logic [ADDR_W-1:0] shift_calc;
   logic [CELL_W-1:0] blank;
   logic [POS_W-1:0]  tab_lut [COLUMNS];

   // Tab table
   for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
      assign tab_lut[g] = POS_W'(tab_next(g, TAB_STOP, COLUMNS));
   end

   assign blank     = {fill_bg_ff, fill_fg_ff, CHAR_SPACE};
   assign is_stream = (item_kind_ff == KIND_STREAM);
   assign printable = (item_char_ff != CHAR_NL) && (item_char_ff != CHAR_CR) &&
                      (item_char_ff != CHAR_TAB);

   // Resolve stream start: pending wrap, then scroll at the bottom
   always_comb begin
      cx0         = item_start_ff ? {1'b0, item_col_ff} : cur_col_ff;
      cy0         = item_start_ff ? {1'b0, item_row_ff} : {1'b0, cur_row_ff};
      wrap        = (cx0 >= POS_W'(COLUMNS));
      cx1         = wrap ? '0 : cx0;
      cy1         = wrap ? cy0 + POS_W'(1) : cy0;
      need_scroll = (cy1 >= POS_W'(ROWS));
      cy2         = need_scroll ? POS_W'(ROWS - 1) : cy1;
      row_sel     = is_stream ? cy2 : {1'b0, item_row_ff};
      col_sel     = is_stream ? cx1 : {1'b0, item_col_ff};
      addr_full   = 16'(row_sel) * 16'(COLUMNS) + 16'(col_sel);
      lines_sel   = is_stream ? POS_W'(1) : item_lines_ff;
      shift_full  = 16'(lines_sel) * 16'(COLUMNS);
      shift_calc  = ADDR_W'(shift_full);
   end

   // Status to the controller
   always_comb begin
      sts.kind            = item_kind_ff;
      sts.nul             = (item_char_ff == CHAR_NUL);
      sts.need_scroll     = need_scroll;
      sts.in_range        = ({1'b0, item_col_ff} < POS_W'(COLUMNS)) &&
                            ({1'b0, item_row_ff} < POS_W'(ROWS));
      sts.lines_zero      = (item_lines_ff == '0);
      sts.lines_full      = (item_lines_ff >= POS_W'(ROWS));
      sts.cnt_at_end      = (cnt_ff == ADDR_W'(CELLS - 1));
      sts.cnt_at_copy_end = (cnt_ff == copy_last_ff);
   end

   // Write port: a moved cell retires first, then the current operation
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = blank;
      mem_raddr = (cmd.op == OP_COPY) ? cnt_ff + shift_ff : addr_ff;
      if (copy_wr_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_wr_addr_ff;
         mem_wdata = rd_data_ff;
      end else begin
         unique case (cmd.op)
            OP_INIT_FILL: begin
               mem_we    = 1'b1;
               mem_wdata = RESET_BLANK;
            end
            OP_FILL: begin
               mem_we = 1'b1;
            end
            OP_CAPTURE: begin
               mem_we    = (item_kind_ff == KIND_PUT);
               mem_waddr = addr_ff;
               mem_wdata = {item_attr_ff, item_char_ff};
            end
            OP_STREAM: begin
               mem_we    = printable;
               mem_waddr = addr_ff;
               mem_wdata = {item_attr_ff, item_char_ff};
            end
            OP_NONE, OP_SETUP, OP_READ, OP_COPY: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cell_mem[mem_raddr];
   end

   // Sweep counter and cursor next values
   always_comb begin
      cnt_in     = cnt_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      unique case (cmd.op)
         OP_SETUP: begin
            cnt_in = '0;
            if (item_kind_ff == KIND_CLEAR ||
                (item_kind_ff == KIND_SCROLL && sts.lines_full)) begin
               cur_col_in = '0;
               cur_row_in = '0;
            end
         end
         OP_INIT_FILL, OP_COPY, OP_FILL: begin
            cnt_in = cnt_ff + ADDR_W'(1);
         end
         OP_STREAM: begin
            cur_row_in = pos_row_ff;
            priority if (item_char_ff == CHAR_NL) begin
               cur_col_in = '0;
               cur_row_in = pos_row_ff + ROW_POS_W'(1);
            end else if (item_char_ff == CHAR_CR) begin
               cur_col_in = '0;
            end else if (item_char_ff == CHAR_TAB) begin
               cur_col_in = tab_lut[pos_col_ff[COL_IDX_W-1:0]];
            end else begin
               cur_col_in = pos_col_ff + POS_W'(1);
            end
         end
         OP_NONE, OP_READ, OP_CAPTURE: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_fg_ff     <= RESET_FG;
         fill_bg_ff     <= RESET_BG;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         cnt_ff         <= '0;
         copy_wr_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FILL_FG: fill_fg_ff <= csr_wdata;
               CSR_FILL_BG: fill_bg_ff <= csr_wdata;
            endcase
         end
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         cnt_ff         <= cnt_in;
         copy_wr_vld_ff <= (cmd.op == OP_COPY);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      copy_wr_addr_ff <= cnt_ff;
      if (cmd.latch) begin
         item_kind_ff  <= req_kind;
         item_start_ff <= req_starts_string;
         item_col_ff   <= req_col;
         item_row_ff   <= req_row;
         item_char_ff  <= req_char_code;
         item_attr_ff  <= req_attr;
         item_lines_ff <= req_scroll_lines;
      end
      if (cmd.op == OP_SETUP) begin
         pos_col_ff   <= cx1;
         pos_row_ff   <= cy2[ROW_POS_W-1:0];
         addr_ff      <= addr_full[ADDR_W-1:0];
         shift_ff     <= shift_calc;
         copy_last_ff <= ADDR_W'(CELLS - 1) - shift_calc;
         old_ff       <= '0;
      end else if (cmd.op == OP_CAPTURE) begin
         old_ff <= rd_data_ff[BYTE_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_old_char_ff   <= old_ff;
         rsp_cursor_col_ff <= cur_col_ff[OCOL_W-1:0];
         rsp_cursor_row_ff <= cur_row_ff[OROW_W-1:0];
      end
   end

   assign rsp_old_char   = rsp_old_char_ff;
   assign rsp_cursor_col = rsp_cursor_col_ff;
   assign rsp_cursor_row = rsp_cursor_row_ff;

endmodule

@@ rtl/core/text_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell text buffer with a stream cursor, direct cell put/read,
// scroll and clear, built as a controller and a datapath.
// ----------------------------------------------------------------------------
//   channel   ports   handshake        word
//   request   req_*   valid / ready    one console command
//   response  rsp_*   valid / ready    old char and cursor after the command
//   config    csr_*   write enable     fill color register write
//
// A command runs through to its loaded result before the next request is accepted;
//   NUL, zero scroll, spare kind or out-of-range cell go straight to the result.
// Sweeps use the single write port: clear and full scroll fill every cell, partial
//   scroll moves rows up then fills, and a stream char that scrolls does so first.
// After reset a clearing pass over every cell runs with req_ready low.
// A waiting response does not stall requests; the next result waits until taken.
// ----------------------------------------------------------------------------
module text_console_writer_top
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF,
   parameter int TAB_STOP = TAB_STOP_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic                 req_starts_string,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [BYTE_W-1:0]    req_char_code,
   input  logic [BYTE_W-1:0]    req_attr,
   input  logic [BYTE_W-1:0]    req_scroll_lines,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_old_char,
   output logic [OCOL_W-1:0]    rsp_cursor_col,
   output logic [OROW_W-1:0]    rsp_cursor_row,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_starts_string (req_starts_string),
      .req_col           (req_col),
      .req_row           (req_row),
      .req_char_code     (req_char_code),
      .req_attr          (req_attr),
      .req_scroll_lines  (req_scroll_lines),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_old_char      (rsp_old_char),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row)
   );

`include "text_console_writer_top_defines.svh"

   // one word in flight: no second accept right behind the first
   `TCW_ASSERT_NEXT(a_single_accept, req_valid && req_ready, !req_ready, "back to back accept")
   // datapath stays quiet while waiting for a request
   `TCW_ASSERT_NOW(a_idle_quiet, req_ready, cmd.op == OP_NONE, "datapath busy while ready")
   // a new result never overwrites one still waiting
   `TCW_ASSERT_NOW(a_no_overwrite, cmd.load_rsp && rsp_valid, rsp_ready, "response overwritten")

endmodule
